// ----- rtl/mbrtu_pkg.sv -----
package mbrtu_pkg;

    localparam int RingDepth    = 512;
    localparam int RingAw       = $clog2(RingDepth);
    localparam int TableDepth   = 1024;
    localparam int TableAw      = $clog2(TableDepth);
    localparam int MaxReadCount = 100;
    localparam int FrameLen     = 8;

    localparam logic [7:0]  FuncReadHolding = 8'h03;
    localparam logic [15:0] CrcInit         = 16'hFFFF;
    localparam logic [15:0] CrcPoly         = 16'hA001;
    localparam logic [7:0]  AddrReset       = 8'd1;
    localparam logic [7:0]  TimeoutReset    = 8'd20;

    localparam logic [1:0] OpRxByte  = 2'd0;
    localparam logic [1:0] OpTick    = 2'd1;
    localparam logic [1:0] OpTblWr   = 2'd2;
    localparam logic [1:0] OpTxSlot  = 2'd3;

    localparam logic RegSlaveAddr = 1'b0;
    localparam logic RegTimeout   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ring_wr;      // store s byte at write pointer
        logic tbl_wr;       // write table word
        logic ring_rd;      // issue ring read at read pointer + offset
        logic [2:0] rd_off;
        logic crc_init;     // frame CRC to init
        logic crc_step;     // fold the registered ring byte into frame CRC
        logic cap_byte;     // capture the registered ring byte into frame slot
        logic [2:0] cap_idx;
        logic rp_inc1;
        logic rp_inc8;
        logic tbl_rd;       // issue table read at response word address
        logic resp_load;    // queue a response from captured frame
        logic tx_emit;      // produce a tx byte into output register
    } mbrtu_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic ring_empty;
        logic len_ge8;
        logic byte_is_addr; // registered ring byte equals slave address
        logic crc_ok;
        logic req_ok;
        logic resp_pending;
        logic need_word;    // next tx byte comes from the table
        logic clearing;     // table clearing pass after reset is running
    } mbrtu_sts_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- rtl/mbrtu_datapath.sv -----
module mbrtu_datapath
    import mbrtu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mbrtu_cmd_t       cmd,
    output mbrtu_sts_t       sts,
    input  logic [7:0]       rx_byte,
    input  logic [9:0]       table_index,
    input  logic [15:0]      table_word,
    input  logic [7:0]       slave_address,
    output logic [7:0]       tx_byte,
    output logic             tx_last
);

    logic [7:0]  ring_mem [RingDepth];
    logic [15:0] tbl_mem  [TableDepth];

    logic [RingAw-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [7:0]  ring_q_reg;
    logic [15:0] tbl_q_reg;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [7:0]  frame_reg [FrameLen];

    logic        pend_reg, pend_next;
    logic [TableAw-1:0] rstart_reg, rstart_next;
    logic [6:0]  rcount_reg, rcount_next;
    logic [7:0]  ridx_reg, ridx_next;
    logic [15:0] rcrc_reg, rcrc_next;

    logic        clr_busy_reg, clr_busy_next;
    logic [TableAw-1:0] clr_addr_reg, clr_addr_next;

    logic [RingAw-1:0] rd_addr, len;
    logic [TableAw-1:0] waddr;
    logic [16:0] start_plus;
    logic [8:0]  body;
    logic [7:0]  off, b;
    logic [15:0] word_q;

    assign rd_addr = rp_reg + RingAw'(cmd.rd_off);
    assign len     = wp_reg - rp_reg;
    // Offset of the current byte inside the word section of the response.
    assign off     = ridx_reg - 8'd3;
    assign waddr   = rstart_reg + TableAw'(off[7:1]);
    assign body    = 9'd3 + {1'b0, rcount_reg, 1'b0};
    assign word_q  = tbl_q_reg;
    assign start_plus = {1'b0, frame_reg[2], frame_reg[3]} + {1'b0, frame_reg[4], frame_reg[5]};

    always_ff @(posedge aclk) begin
        if (cmd.ring_wr) begin
            ring_mem[wp_reg] <= rx_byte;
        end
        if (cmd.ring_rd) begin
            ring_q_reg <= ring_mem[rd_addr];
        end
        // After reset the table is cleared one entry per cycle.
        if (clr_busy_reg) begin
            tbl_mem[clr_addr_reg] <= 16'd0;
        end else if (cmd.tbl_wr && (32'(table_index) < TableDepth)) begin
            tbl_mem[TableAw'(table_index)] <= table_word;
        end
        if (cmd.tbl_rd) begin
            tbl_q_reg <= tbl_mem[waddr];
        end
        if (cmd.cap_byte) begin
            frame_reg[cmd.cap_idx] <= ring_q_reg;
        end
    end

    always_comb begin
        wp_next = wp_reg + RingAw'(cmd.ring_wr);
        rp_next = rp_reg;
        if (cmd.rp_inc1) rp_next = rp_reg + RingAw'(1);
        if (cmd.rp_inc8) rp_next = rp_reg + RingAw'(FrameLen);
        fcrc_next = fcrc_reg;
        if (cmd.crc_init) fcrc_next = CrcInit;
        else if (cmd.crc_step) fcrc_next = crc_byte(fcrc_reg, ring_q_reg);
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + TableAw'(1);
            if (clr_addr_reg == TableAw'(TableDepth - 1)) clr_busy_next = 1'b0;
        end
    end

    // Response byte selection.
    always_comb begin
        tx_last = 1'b0;
        if (ridx_reg == 8'd0)                b = slave_address;
        else if (ridx_reg == 8'd1)           b = FuncReadHolding;
        else if (ridx_reg == 8'd2)           b = {rcount_reg, 1'b0};
        else if ({1'b0, ridx_reg} < body)    b = off[0] ? word_q[7:0] : word_q[15:8];
        else if ({1'b0, ridx_reg} == body)   b = rcrc_reg[7:0];
        else begin
            b = rcrc_reg[15:8];
            tx_last = 1'b1;
        end
        tx_byte = b;
    end

    always_comb begin
        pend_next   = pend_reg;
        rstart_next = rstart_reg;
        rcount_next = rcount_reg;
        ridx_next   = ridx_reg;
        rcrc_next   = rcrc_reg;
        if (cmd.resp_load) begin
            pend_next   = 1'b1;
            rstart_next = TableAw'({frame_reg[2], frame_reg[3]});
            rcount_next = 7'(frame_reg[5]);
            ridx_next   = 8'd0;
            rcrc_next   = CrcInit;
        end else if (cmd.tx_emit) begin
            if ({1'b0, ridx_reg} < body) rcrc_next = crc_byte(rcrc_reg, b);
            if (tx_last) begin
                pend_next = 1'b0;
                ridx_next = 8'd0;
            end else begin
                ridx_next = ridx_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            fcrc_reg     <= CrcInit;
            pend_reg     <= 1'b0;
            rstart_reg   <= '0;
            rcount_reg   <= '0;
            ridx_reg     <= '0;
            rcrc_reg     <= CrcInit;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            fcrc_reg     <= fcrc_next;
            pend_reg     <= pend_next;
            rstart_reg   <= rstart_next;
            rcount_reg   <= rcount_next;
            ridx_reg     <= ridx_next;
            rcrc_reg     <= rcrc_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb begin
        sts.ring_empty   = (wp_reg == rp_reg);
        sts.len_ge8      = (32'(len) >= FrameLen);
        sts.byte_is_addr = (ring_q_reg == slave_address);
        sts.crc_ok       = (fcrc_reg == {frame_reg[7], frame_reg[6]});
        sts.req_ok       = (frame_reg[1] == FuncReadHolding)
                           && (32'(start_plus) <= TableDepth)
                           && (32'({frame_reg[4], frame_reg[5]}) <= MaxReadCount);
        sts.resp_pending = pend_reg;
        // Both bytes of a word are read from the table when they are sent.
        sts.need_word    = ({1'b0, ridx_reg} < body) && (ridx_reg >= 8'd3);
        sts.clearing     = clr_busy_reg;
    end

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> ({1'b0, ridx_reg} <= body + 9'd1))
        else $error("response index past end");
    a_idle_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        !pend_reg |-> (ridx_reg == 8'd0))
        else $error("index nonzero while idle");
    a_count_lim: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (32'(rcount_reg) <= MaxReadCount))
        else $error("response count out of range");
`endif

endmodule

// ----- rtl/mbrtu_ctrl.sv -----
module mbrtu_ctrl
    import mbrtu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    output logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  timeout_ticks,
    input  mbrtu_sts_t  sts,
    output mbrtu_cmd_t  cmd,
    output logic        out_load
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_HUNT   = 8'b00000010,
        S_HCHK   = 8'b00000100,
        S_FRD    = 8'b00001000,
        S_FCHK   = 8'b00010000,
        S_FEND   = 8'b00100000,
        S_TXRD   = 8'b01000000,
        S_TXOUT  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [7:0] delay_reg, delay_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       ov_reg, ov_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg && !sts.clearing;
    assign accept    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb begin
        cmd        = '0;
        out_load   = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        delay_next = delay_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (opcode)
                        OpRxByte: cmd.ring_wr = 1'b1;
                        OpTblWr:  cmd.tbl_wr  = 1'b1;
                        OpTick: begin
                            delay_next = delay_reg + 8'd1;
                            if (!phase_reg) begin
                                state_next = S_HUNT;
                            end else if (sts.len_ge8) begin
                                phase_next   = 1'b0;
                                cmd.ring_rd  = 1'b1;
                                cmd.crc_init = 1'b1;
                                cnt_next     = 4'd0;
                                state_next   = S_FRD;
                            end else if ((delay_reg + 8'd1) >= timeout_ticks) begin
                                phase_next  = 1'b0;
                                cmd.rp_inc1 = 1'b1;
                            end
                        end
                        OpTxSlot: begin
                            if (sts.resp_pending) begin
                                if (sts.need_word) begin
                                    cmd.tbl_rd = 1'b1;
                                    state_next = S_TXRD;
                                end else begin
                                    state_next = S_TXOUT;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HUNT: begin
                if (sts.ring_empty) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.ring_rd = 1'b1;
                    state_next  = S_HCHK;
                end
            end
            S_HCHK: begin
                if (sts.byte_is_addr) begin
                    phase_next = 1'b1;
                    delay_next = 8'd0;
                    state_next = S_IDLE;
                end else begin
                    cmd.rp_inc1 = 1'b1;
                    state_next  = S_HUNT;
                end
            end
            S_FRD: begin
                // Ring read data for byte cnt is now registered.
                cmd.cap_byte = 1'b1;
                cmd.cap_idx  = cnt_reg[2:0];
                cmd.crc_step = (cnt_reg < 4'd6);
                if (cnt_reg == 4'd7) begin
                    state_next = S_FCHK;
                end else begin
                    cmd.ring_rd = 1'b1;
                    cmd.rd_off  = cnt_reg[2:0] + 3'd1;
                end
                cnt_next = cnt_reg + 4'd1;
            end
            S_FCHK: begin
                if (sts.crc_ok) begin
                    cmd.rp_inc8   = 1'b1;
                    cmd.resp_load = sts.req_ok;
                end else begin
                    cmd.rp_inc1 = 1'b1;
                end
                state_next = S_FEND;
            end
            S_FEND: state_next = S_IDLE;
            S_TXRD: state_next = S_TXOUT;
            S_TXOUT: begin
                cmd.tx_emit = 1'b1;
                out_load    = 1'b1;
                ov_next     = 1'b1;
                state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
            delay_reg <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");
    a_emit_ov: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> ov_reg)
        else $error("emitted item not held");
    a_frame_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FRD) |-> (cnt_reg <= 4'd7))
        else $error("frame byte counter overrun");
`endif

endmodule

// ----- rtl/modbus_rtu_read_holding_slave.sv -----
// A transmit slot item gives its byte through S_TXRD (if a table word is needed) and S_TXOUT.
// Items are taken one at a time; byte, table write and ready-state ticks stay in S_IDLE,
// a hunting tick runs S_HUNT and S_HCHK per ring byte examined, plus S_HUNT if the ring runs empty,
// a frame check tick S_FRD, S_FCHK, S_FEND. A result in the output register blocks the next item.
// Reset (aresetn, synchronous, active low) clears pointers, phase and response state, then
// clears the table entry by entry with s_tready low; the ring contents stay undefined.
module modbus_rtu_read_holding_slave
    import mbrtu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] opcode, [9:2] rx_byte, [19:10] table_index, [35:20] table_word
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] tx_byte
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    mbrtu_cmd_t cmd;
    mbrtu_sts_t sts;
    logic [7:0] addr_reg, tmo_reg;
    logic [7:0] txb;
    logic       txl, out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= AddrReset;
            tmo_reg  <= TimeoutReset;
        end else if (cfg_we) begin
            case (cfg_index)
                RegSlaveAddr: addr_reg <= cfg_wdata;
                RegTimeout:   tmo_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata <= txb;
            m_tlast <= txl;
        end
    end

    mbrtu_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .opcode        (s_tdata[1:0]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .timeout_ticks (tmo_reg),
        .sts           (sts),
        .cmd           (cmd),
        .out_load      (out_load)
    );

    mbrtu_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .rx_byte       (s_tdata[9:2]),
        .table_index   (s_tdata[19:10]),
        .table_word    (s_tdata[35:20]),
        .slave_address (addr_reg),
        .tx_byte       (txb),
        .tx_last       (txl)
    );

endmodule
